>>> rtl/lfu_pkg.sv
`timescale 1ns / 1ps

package lfu_pkg;

  // table geometry
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // field widths
  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int USES_W  = 32;
  localparam int STAMP_W = 40;
  localparam int CAP_W   = 5;
  localparam int EXT_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;

  // register port
  localparam int ADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic [DATA_W-1:0] NOT_FOUND = '1;

  typedef struct packed {
    logic              is_set;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] value;
  } res_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DATA_W-1:0]  data;
    logic [USES_W-1:0]  uses;
    logic [STAMP_W-1:0] stamp;
  } row_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

>>> rtl/lfu_cache_table.sv
`timescale 1ns / 1ps

// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_type, req_key, req_value
// resp      out        resp_valid/resp_stall key_found, read_value
// cfg       in         APB psel/penable      capacity_in_use at byte address 0
//
// each word passes from accept to result register through a scan of every slot
// of the table memory plus its read latency, a write-back state and a hand-off
// state; the next word is accepted only after the result has gone to the output
// register, so the table does not take a new word while one is in flight.
// reset clears valid marks, occupancy, access clock and capacity (16);
// no word is taken while reset is high.
// a stalled result sits in the output register; the table takes the next word
// while it waits, and holds its own result until the register frees.

module lfu_cache_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  logic                        req_type,
  input  logic signed [31:0]          req_key,
  input  logic signed [31:0]          req_value,
  output logic                        resp_valid,
  input  logic                        resp_stall,
  output logic                        key_found,
  output logic signed [31:0]          read_value,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lfu_pkg::ADDR_W-1:0]  paddr,
  input  logic [lfu_pkg::PDATA_W-1:0] pwdata,
  output logic [lfu_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import lfu_pkg::*;

  logic [CAP_W-1:0] capacity_in_use;
  logic             core_idle;
  logic             req_fire;
  req_t             req;
  res_t             res;
  logic             res_valid;
  logic             res_take;

  // register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? PDATA_W'(capacity_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
      capacity_in_use <= pwdata[CAP_W-1:0];
    end
  end

  // request side
  assign req_stall = rst || !core_idle;
  assign req_fire  = req_valid && !req_stall;
  assign req       = '{is_set: req_type, key: req_key, value: req_value};

  lfu_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity_in_use),
    .req       (req),
    .req_fire  (req_fire),
    .idle      (core_idle),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take)
  );

  // output register
  assign res_take = res_valid && (!resp_valid || !resp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (res_take) begin
      resp_valid <= 1'b1;
    end else if (!resp_stall) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      key_found  <= res.found;
      read_value <= res.value;
    end
  end

endmodule

>>> rtl/lfu_engine.sv
`timescale 1ns / 1ps

module lfu_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lfu_pkg::CAP_W-1:0] capacity,
  input  lfu_pkg::req_t             req,
  input  logic                      req_fire,
  output logic                      idle,
  output lfu_pkg::res_t             res,
  output logic                      res_valid,
  input  logic                      res_take
);
  import lfu_pkg::*;

  state_t state, state_next;

  // slot table and valid marks
  row_t mem [MAX_ENTRIES];
  row_t rrow;
  logic [MAX_ENTRIES-1:0] slot_valid;

  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   occupied;
  logic [STAMP_W-1:0] access_clock;
  req_t               cur;

  // scan results
  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [DATA_W-1:0]  hit_data;
  logic [USES_W-1:0]  hit_uses;
  logic               free_ok;
  logic [IDX_W-1:0]   free_idx;
  logic               vic_ok;
  logic [IDX_W-1:0]   vic_idx;
  logic [USES_W-1:0]  vic_uses;
  logic [STAMP_W-1:0] vic_stamp;

  logic [CNT_W-1:0]   cnt_m1;
  logic [IDX_W-1:0]   chk_idx;
  logic               chk_on;
  logic               chk_live;
  logic [IDX_W-1:0]   raddr;

  // write-back decision
  logic               mem_we;
  logic [IDX_W-1:0]   waddr;
  row_t               wrow;
  logic               set_valid;
  logic               clk_adv;
  logic [CNT_W-1:0]   occ_v;
  logic               occ_we;
  res_t               res_v;
  logic [EXT_W-1:0]   cap_ext;
  logic [EXT_W-1:0]   cap_eff;
  logic [STAMP_W-1:0] stamp_new;
  logic [USES_W-1:0]  uses_inc;
  logic               take_free;
  logic [IDX_W-1:0]   target;

  assign cnt_m1   = cnt - CNT_W'(1);
  assign chk_idx  = cnt_m1[IDX_W-1:0];
  assign chk_on   = (state == ST_SCAN) && (cnt != '0);
  assign chk_live = chk_on && slot_valid[chk_idx];
  assign raddr    = (cnt == CNT_W'(MAX_ENTRIES)) ? '0 : cnt[IDX_W-1:0];

  assign cap_ext   = EXT_W'(capacity);
  assign cap_eff   = (cap_ext > EXT_W'(MAX_ENTRIES)) ? EXT_W'(MAX_ENTRIES) : cap_ext;
  assign stamp_new = access_clock + STAMP_W'(1);
  assign uses_inc  = (hit_uses == '1) ? hit_uses : hit_uses + USES_W'(1);

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  // synchronous table memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wrow;
    end
    rrow <= mem[raddr];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and write-back decision
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    waddr      = hit_idx;
    wrow       = '{key: cur.key, data: hit_data, uses: uses_inc, stamp: stamp_new};
    set_valid  = 1'b0;
    clk_adv    = 1'b0;
    occ_we     = 1'b0;
    occ_v      = occupied;
    take_free  = 1'b0;
    target     = '0;
    res_v      = '{found: hit, value: NOT_FOUND};
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt == CNT_W'(MAX_ENTRIES)) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_next = ST_DONE;
        if (!cur.is_set) begin
          // get: hit bumps the count and stamp
          if (hit) begin
            mem_we      = 1'b1;
            clk_adv     = 1'b1;
            res_v.value = hit_data;
          end
        end else if (cap_eff == '0) begin
          // storing disabled: report only
          if (hit) begin
            res_v.value = hit_data;
          end
        end else if (hit) begin
          // set hit: overwrite and count a use
          mem_we      = 1'b1;
          clk_adv     = 1'b1;
          wrow.data   = cur.value;
          res_v.value = cur.value;
        end else begin
          // set miss: free slot or evict the victim
          take_free = (EXT_W'(occupied) < cap_eff) && free_ok;
          if (take_free) begin
            target = free_idx;
          end else if (vic_ok) begin
            target = vic_idx;
          end
          if (!take_free && slot_valid[target] && (occ_v != '0)) begin
            occ_v = occ_v - CNT_W'(1);
          end
          if (occ_v < CNT_W'(MAX_ENTRIES)) begin
            occ_v = occ_v + CNT_W'(1);
          end
          occ_we    = 1'b1;
          mem_we    = 1'b1;
          clk_adv   = 1'b1;
          set_valid = 1'b1;
          waddr     = target;
          wrow      = '{key: cur.key, data: cur.value, uses: USES_W'(1), stamp: stamp_new};
        end
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      occupied     <= '0;
      access_clock <= '0;
      cnt          <= '0;
      hit          <= 1'b0;
      free_ok      <= 1'b0;
      vic_ok       <= 1'b0;
    end else begin
      if (state == ST_IDLE && req_fire) begin
        cnt     <= '0;
        hit     <= 1'b0;
        free_ok <= 1'b0;
        vic_ok  <= 1'b0;
      end
      if (state == ST_SCAN) begin
        cnt <= cnt + CNT_W'(1);
        // key match, first free slot, least-used oldest victim
        if (chk_live && !hit && (rrow.key == cur.key)) begin
          hit <= 1'b1;
        end
        if (chk_on && !slot_valid[chk_idx] && !free_ok) begin
          free_ok <= 1'b1;
        end
        if (chk_live) begin
          vic_ok <= 1'b1;
        end
      end
      if (set_valid) begin
        slot_valid[waddr] <= 1'b1;
      end
      if (occ_we) begin
        occupied <= occ_v;
      end
      if (clk_adv) begin
        access_clock <= stamp_new;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_fire) begin
      cur <= req;
    end
    if (chk_live && !hit && (rrow.key == cur.key)) begin
      hit_idx  <= chk_idx;
      hit_data <= rrow.data;
      hit_uses <= rrow.uses;
    end
    if (chk_on && !slot_valid[chk_idx] && !free_ok) begin
      free_idx <= chk_idx;
    end
    if (chk_live && (!vic_ok || (rrow.uses < vic_uses) ||
        ((rrow.uses == vic_uses) && (rrow.stamp < vic_stamp)))) begin
      vic_idx   <= chk_idx;
      vic_uses  <= rrow.uses;
      vic_stamp <= rrow.stamp;
    end
    if (state == ST_WRITE) begin
      res <= res_v;
    end
  end

endmodule
